>>> src/gtfi_pkg.sv
// Shared types, opcodes and constants for the grid Taylor force interpolator.
package gtfi_pkg;

   localparam int GRID_X_DEF = 32;
   localparam int GRID_Y_DEF = 32;
   localparam int GRID_Z_DEF = 32;

   localparam int CW     = 8;   // node coordinate width, grids up to 256 per axis
   localparam int XW     = 38;  // cross sums and 4*h
   localparam int MA_W   = 41;  // multiplier operand A
   localparam int MB_W   = 18;  // multiplier operand B
   localparam int PR_W   = MA_W + MB_W;
   localparam int D4_W   = 58;
   localparam int SL_W   = 60;
   localparam int ACC_W  = 64;
   localparam int IDX_W  = 5;
   localparam int MEM_AW = 17;
   localparam int NODES  = 19;
   localparam logic [IDX_W-1:0] NODE_LAST = IDX_W'(NODES - 1);

   localparam logic [3:0] OP_NOP   = 4'd0;
   localparam logic [3:0] OP_COORD = 4'd1;
   localparam logic [3:0] OP_RD    = 4'd2;
   localparam logic [3:0] OP_INIT  = 4'd3;
   localparam logic [3:0] OP_D4    = 4'd4;
   localparam logic [3:0] OP_FG    = 4'd5;
   localparam logic [3:0] OP_FD    = 4'd6;
   localparam logic [3:0] OP_FIN   = 4'd7;
   localparam logic [3:0] OP_DHI   = 4'd8;
   localparam logic [3:0] OP_DLO   = 4'd9;

   localparam logic [1:0] PICK_MID = 2'd0;
   localparam logic [1:0] PICK_HI  = 2'd1;
   localparam logic [1:0] PICK_LO  = 2'd2;

   localparam logic [1:0] GRID_POT = 2'd0;
   localparam logic [1:0] GRID_FZ  = 2'd3;

   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_INV_X    = 3'd3;
   localparam logic [2:0] REG_INV_Y    = 3'd4;
   localparam logic [2:0] REG_INV_Z    = 3'd5;
   localparam logic [2:0] REG_CAP      = 3'd6;
   localparam logic [2:0] REG_MODE     = 3'd7;

   typedef struct packed {
      logic [3:0]       op;
      logic [1:0]       a;
      logic [1:0]       b;
      logic [IDX_W-1:0] idx;
      logic [1:0]       grid;
      logic             capture;
      logic             emit;
   } dp_cmd_type;

   typedef struct packed {
      logic bad;
      logic rsp_busy;
   } dp_status_type;

   typedef struct packed {
      logic [2:0][31:0] origin;
      logic [2:0][31:0] inv;
      logic [30:0]      cap;
      logic [3:0]       mode;
   } cfg_type;

   // per-axis pick of the stencil node: center, axis pairs, then cross corners
   function automatic logic [2:0][1:0] node_pick(input logic [IDX_W-1:0] idx);
      logic [2:0][1:0]  p;
      logic [IDX_W-1:0] u;
      logic [3:0]       t;
      logic [1:0]       ax0;
      logic [1:0]       ax1;
      logic [1:0]       c0;
      logic [1:0]       c1;
      begin
         p   = {3{PICK_MID}};
         u   = idx - IDX_W'(1);
         t   = 4'(idx - IDX_W'(7));
         ax0 = (t[3:2] == 2'd2) ? 2'd1 : 2'd0;
         ax1 = (t[3:2] == 2'd0) ? 2'd1 : 2'd2;
         unique case (t[1:0])
            2'd0: begin c0 = PICK_HI; c1 = PICK_HI; end
            2'd1: begin c0 = PICK_HI; c1 = PICK_LO; end
            2'd2: begin c0 = PICK_LO; c1 = PICK_LO; end
            default: begin c0 = PICK_LO; c1 = PICK_HI; end
         endcase
         if (idx >= IDX_W'(1) && idx <= IDX_W'(6)) begin
            p[u[2:1]] = idx[0] ? PICK_HI : PICK_LO;
         end else if (idx >= IDX_W'(7)) begin
            p[ax0] = c0;
            p[ax1] = c1;
         end
         return p;
      end
   endfunction

endpackage

>>> src/gtfi_ctrl.sv
// Sequencer for the interpolator: issues node reads and multiply steps.
module gtfi_ctrl import gtfi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept_query,
   input  logic          grid_mode,
   input  dp_status_type status,
   output logic          ready,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_COORD = 4'd1;
   localparam logic [3:0] S_NODE  = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_READ  = 4'd4;
   localparam logic [3:0] S_INIT  = 4'd5;
   localparam logic [3:0] S_D4    = 4'd6;
   localparam logic [3:0] S_FG    = 4'd7;
   localparam logic [3:0] S_FD    = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_GAP   = 4'd10;
   localparam logic [3:0] S_DHI   = 4'd11;
   localparam logic [3:0] S_DLO   = 4'd12;
   localparam logic [3:0] S_DRAIN = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       a_ff, a_in;
   logic [1:0]       b_ff, b_in;
   logic [1:0]       grid_ff, grid_in;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      grid_in     = grid_ff;
      ready       = 1'b0;
      cmd         = '0;
      cmd.op      = OP_NOP;
      cmd.a       = a_ff;
      cmd.b       = b_ff;
      cmd.idx     = idx_ff;
      cmd.grid    = grid_ff;
      unique case (state_ff)
         S_IDLE: begin
            ready = 1'b1;
            if (accept_query) begin
               cmd.capture = 1'b1;
               state_in    = S_COORD;
            end
         end
         S_COORD: begin
            cmd.op   = OP_COORD;
            state_in = S_NODE;
         end
         S_NODE: state_in = S_CHECK;
         S_CHECK: begin
            grid_in = GRID_POT;
            idx_in  = '0;
            state_in = status.bad ? S_OUT : S_READ;
         end
         S_READ: begin
            cmd.op = OP_RD;
            if (idx_ff == NODE_LAST) begin
               idx_in   = '0;
               state_in = S_INIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            a_in     = 2'd0;
            b_in     = 2'd0;
            state_in = S_D4;
         end
         S_D4: begin
            cmd.op = OP_D4;
            if (b_ff == 2'd2) begin
               b_in = 2'd0;
               if (a_ff == 2'd2) begin
                  a_in     = 2'd0;
                  state_in = S_FG;
               end else begin
                  a_in = a_ff + 2'd1;
               end
            end else begin
               b_in = b_ff + 2'd1;
            end
         end
         S_FG: begin
            cmd.op = OP_FG;
            if (a_ff == 2'd2) begin
               a_in     = 2'd0;
               state_in = S_FD;
            end else begin
               a_in = a_ff + 2'd1;
            end
         end
         S_FD: begin
            cmd.op = OP_FD;
            if (a_ff == 2'd2) begin
               a_in     = 2'd0;
               state_in = S_FIN;
            end else begin
               a_in = a_ff + 2'd1;
            end
         end
         S_FIN: begin
            cmd.op = OP_FIN;
            if (grid_mode) begin
               if (grid_ff == GRID_FZ) begin
                  state_in = S_DRAIN;
               end else begin
                  grid_in  = grid_ff + 2'd1;
                  idx_in   = '0;
                  state_in = S_READ;
               end
            end else begin
               a_in     = 2'd0;
               state_in = S_GAP;
            end
         end
         S_GAP: state_in = S_DHI;
         S_DHI: begin
            cmd.op   = OP_DHI;
            state_in = S_DLO;
         end
         S_DLO: begin
            cmd.op = OP_DLO;
            if (a_ff == 2'd2) begin
               a_in     = 2'd0;
               state_in = S_DRAIN;
            end else begin
               a_in     = a_ff + 2'd1;
               state_in = S_DHI;
            end
         end
         S_DRAIN: state_in = S_OUT;
         S_OUT: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         grid_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         grid_ff  <= grid_in;
      end
   end

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.rsp_busy) else $error("emit while result held");
   a_capture_next: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_COORD) else $error("capture not followed by coord");
   a_read_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && idx_ff == NODE_LAST) |=> state_ff == S_INIT)
      else $error("node read sweep overran");
`endif

endmodule

>>> src/gtfi_datapath.sv
// Datapath: grid memory, node mapping, stencil capture, shared MAC and result register.
module gtfi_datapath import gtfi_pkg::*; #(
   parameter int GRID_X = GRID_X_DEF,
   parameter int GRID_Y = GRID_Y_DEF,
   parameter int GRID_Z = GRID_Z_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  cfg_type       cfg,
   input  logic          load_we,
   input  logic [1:0]    table_select,
   input  logic [14:0]   grid_address,
   input  logic [31:0]   grid_value,
   input  logic [31:0]   pos_x,
   input  logic [31:0]   pos_y,
   input  logic [31:0]   pos_z,
   input  logic          clear_energy,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   force_x,
   output logic [31:0]   force_y,
   output logic [31:0]   force_z,
   output logic [31:0]   potential,
   output logic [63:0]   energy_total,
   output logic          out_of_range
);

   localparam logic [8:0] SIZE_V [3] = '{9'(GRID_X), 9'(GRID_Y), 9'(GRID_Z)};

   logic [31:0] mem [0:(1 << MEM_AW) - 1];
   logic [31:0] rdata_ff;
   logic [MEM_AW-1:0] rd_addr;

   logic [3:0]       op_ff;
   logic [1:0]       a_ff;
   logic [1:0]       grid_ff;
   logic [IDX_W-1:0] idx_ff;

   logic signed [31:0]        pos_ff [3];
   logic signed [65:0]        cprod_ff [3];
   logic                      bad_ff;
   logic [CW-1:0]             mid_ff [3];
   logic [CW-1:0]             lo_ff [3];
   logic [CW-1:0]             hi_ff [3];
   logic signed [15:0]        f_ff [3];
   logic signed [31:0]        w_ff;
   logic signed [31:0]        wp_ff [3];
   logic signed [31:0]        wm_ff [3];
   logic signed [XW-1:0]      x_ff [3];
   logic signed [D4_W-1:0]    d4_ff [3];
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [PR_W-1:0]    prod_ff;
   logic signed [ACC_W-1:0]   dacc_ff;
   logic [MA_W-2:0]           m_ff [3];
   logic                      neg_ff [3];
   logic signed [ACC_W-1:0]   force_ff [3];
   logic signed [31:0]        pot_ff;
   logic signed [ACC_W-1:0]   energy_ff;

   logic                      rsp_valid_ff;
   logic [31:0]               rsp_f_ff [3];
   logic [31:0]               rsp_pot_ff;
   logic [63:0]               rsp_energy_ff;
   logic                      rsp_oor_ff;

   // combinational helpers
   logic signed [32:0]        diff [3];
   logic signed [65:0]        cprod_in [3];
   logic signed [49:0]        cc [3];
   logic signed [50:0]        tt [3];
   logic signed [50:0]        nn [3];
   logic                      bad_ax [3];
   logic [CW-1:0]             hi_n [3];
   logic [2:0][1:0]           pick;
   logic [CW-1:0]             crd [3];
   logic [31:0]               lin;
   logic signed [32:0]        g [3];
   logic signed [33:0]        h [3];
   logic signed [XW-1:0]      xs [3][3];
   logic signed [SL_W-1:0]    slope [3];
   logic signed [SL_W-1:0]    sq [3];
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [ACC_W-1:0]   rnd;
   logic signed [31:0]        pot_v;
   logic signed [64:0]        esum;
   logic signed [ACC_W-1:0]   esat;
   logic [IDX_W-1:0]          rd_u;
   logic [3:0]                rd_t;
   logic signed [XW-1:0]      dx;
   logic signed [ACC_W-1:0]   pr;
   logic signed [ACC_W-1:0]   capv;
   logic signed [ACC_W-1:0]   fcl [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a]     = 33'(pos_ff[a]) - 33'($signed(cfg.origin[a]));
         cprod_in[a] = 66'(diff[a]) * 66'($signed({1'b0, cfg.inv[a]}));
         cc[a]       = 50'(cprod_ff[a] >>> 16);
         tt[a]       = 51'(cc[a]) + 51'sd32768;
         nn[a]       = tt[a] >>> 16;
         bad_ax[a]   = tt[a][50] || (nn[a] < 51'sd1)
                       || (nn[a] > $signed(51'(SIZE_V[a]) - 51'd2));
         hi_n[a]     = nn[a][CW-1:0] + CW'(1);
         if (cfg.mode[a+1] && {1'b0, hi_n[a]} == SIZE_V[a] - 9'd1) begin
            hi_n[a] = '0;
         end
      end
   end

   always_comb begin
      pick = node_pick(cmd.idx);
      for (int a = 0; a < 3; a++) begin
         unique case (pick[a])
            PICK_HI: crd[a] = hi_ff[a];
            PICK_LO: crd[a] = lo_ff[a];
            default: crd[a] = mid_ff[a];
         endcase
      end
      lin = (32'(crd[0]) * 32'(GRID_Y) + 32'(crd[1])) * 32'(GRID_Z) + 32'(crd[2]);
      rd_addr = {cmd.grid, lin[14:0]};
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         g[a] = 33'(wp_ff[a]) - 33'(wm_ff[a]);
         h[a] = 34'(wp_ff[a]) - (34'(w_ff) <<< 1) + 34'(wm_ff[a]);
      end
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            if (a == b) xs[a][b] = XW'(h[a]) <<< 2;
            else        xs[a][b] = x_ff[a + b - 1];
         end
         slope[a] = (SL_W'(g[a]) <<< 17) + SL_W'(d4_ff[a]);
         sq[a]    = slope[a] >>> 18;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_D4: begin
            mul_a = MA_W'(xs[cmd.a][cmd.b]);
            mul_b = MB_W'(f_ff[cmd.b]);
         end
         OP_FG: begin
            mul_a = MA_W'(g[cmd.a]);
            mul_b = MB_W'(f_ff[cmd.a]);
         end
         OP_FD: begin
            mul_a = MA_W'(d4_ff[cmd.a] >>> 18);
            mul_b = MB_W'(f_ff[cmd.a]);
         end
         OP_DHI: begin
            mul_a = $signed({1'b0, m_ff[cmd.a]});
            mul_b = $signed({2'b00, cfg.inv[cmd.a][31:16]});
         end
         OP_DLO: begin
            mul_a = $signed({1'b0, m_ff[cmd.a]});
            mul_b = $signed({2'b00, cfg.inv[cmd.a][15:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      rnd = (acc_ff + ACC_W'(65536)) >>> 17;
      if (rnd > 64'sd2147483647)       pot_v = 32'sh7FFFFFFF;
      else if (rnd < -64'sd2147483648) pot_v = 32'sh80000000;
      else                             pot_v = rnd[31:0];
      esum = 65'(energy_ff) + 65'(pot_v);
      if (esum > 65'sh0_7FFF_FFFF_FFFF_FFFF)       esat = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (esum < -65'sh0_8000_0000_0000_0000) esat = 64'sh8000_0000_0000_0000;
      else                                         esat = esum[63:0];
      rd_u = idx_ff - IDX_W'(1);
      rd_t = 4'(idx_ff - IDX_W'(7));
      dx   = XW'($signed(rdata_ff));
      pr   = dacc_ff + ACC_W'(prod_ff >>> 16);
      capv = $signed({33'b0, cfg.cap});
      for (int a = 0; a < 3; a++) begin
         if (force_ff[a] > capv)       fcl[a] = capv;
         else if (force_ff[a] < -capv) fcl[a] = -capv;
         else                          fcl[a] = force_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         mem[{table_select, grid_address}] <= grid_value;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_NOP;
      end else begin
         op_ff <= cmd.op;
      end
      a_ff    <= cmd.a;
      grid_ff <= cmd.grid;
      idx_ff  <= cmd.idx;
      prod_ff <= mul_a * mul_b;
      if (cmd.capture) begin
         pos_ff[0] <= pos_x;
         pos_ff[1] <= pos_y;
         pos_ff[2] <= pos_z;
      end
      if (cmd.op == OP_COORD) begin
         for (int a = 0; a < 3; a++) cprod_ff[a] <= cprod_in[a];
      end
      unique case (op_ff)
         OP_COORD: begin
            for (int a = 0; a < 3; a++) begin
               mid_ff[a] <= nn[a][CW-1:0];
               lo_ff[a]  <= nn[a][CW-1:0] - CW'(1);
               hi_ff[a]  <= hi_n[a];
               f_ff[a]   <= {~tt[a][15], tt[a][14:0]};
            end
         end
         OP_RD: begin
            if (idx_ff == '0) begin
               w_ff <= rdata_ff;
            end else if (idx_ff <= IDX_W'(6)) begin
               if (idx_ff[0]) wp_ff[rd_u[2:1]] <= rdata_ff;
               else           wm_ff[rd_u[2:1]] <= rdata_ff;
            end else begin
               unique case (rd_t[1:0])
                  2'd0:    x_ff[rd_t[3:2]] <= dx;
                  2'd2:    x_ff[rd_t[3:2]] <= x_ff[rd_t[3:2]] + dx;
                  default: x_ff[rd_t[3:2]] <= x_ff[rd_t[3:2]] - dx;
               endcase
            end
         end
         OP_INIT: begin
            acc_ff <= ACC_W'(w_ff) <<< 17;
            for (int a = 0; a < 3; a++) d4_ff[a] <= '0;
         end
         OP_D4: d4_ff[a_ff] <= d4_ff[a_ff] + D4_W'(prod_ff);
         OP_FG, OP_FD: acc_ff <= acc_ff + ACC_W'(prod_ff);
         OP_FIN: begin
            if (grid_ff == GRID_POT) begin
               pot_ff <= pot_v;
               for (int a = 0; a < 3; a++) begin
                  neg_ff[a] <= sq[a][SL_W-1];
                  m_ff[a]   <= sq[a][SL_W-1] ? (MA_W-1)'(-sq[a]) : (MA_W-1)'(sq[a]);
               end
            end else begin
               force_ff[grid_ff - 2'd1] <= ACC_W'(pot_v);
            end
         end
         OP_DHI: dacc_ff <= ACC_W'(prod_ff);
         OP_DLO: force_ff[a_ff] <= neg_ff[a_ff] ? pr : -pr;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_ff    <= 1'b0;
         energy_ff <= '0;
      end else begin
         if (op_ff == OP_COORD) begin
            bad_ff <= bad_ax[0] || bad_ax[1] || bad_ax[2];
         end
         if (cmd.capture && clear_energy) begin
            energy_ff <= '0;
         end else if (op_ff == OP_FIN && grid_ff == GRID_POT) begin
            energy_ff <= esat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_energy_ff <= energy_ff;
         rsp_oor_ff    <= bad_ff;
         rsp_pot_ff    <= bad_ff ? 32'd0 : pot_ff;
         for (int a = 0; a < 3; a++) begin
            rsp_f_ff[a] <= bad_ff ? 32'd0 : fcl[a][31:0];
         end
      end
   end

   assign status.bad      = bad_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign force_x         = rsp_f_ff[0];
   assign force_y         = rsp_f_ff[1];
   assign force_z         = rsp_f_ff[2];
   assign potential       = rsp_pot_ff;
   assign energy_total    = rsp_energy_ff;
   assign out_of_range    = rsp_oor_ff;

`ifndef SYNTH
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (rsp_f_ff[0] == 32'd0 && rsp_f_ff[1] == 32'd0
         && rsp_f_ff[2] == 32'd0 && rsp_pot_ff == 32'd0))
      else $error("flagged result carries data");
   a_stencil: assert property (@(posedge clock) disable iff (reset)
      (op_ff == OP_COORD && !(bad_ax[0] || bad_ax[1] || bad_ax[2]))
         |=> mid_ff[0] == lo_ff[0] + CW'(1))
      else $error("stencil coordinates inconsistent");
   a_energy_hold: assert property (@(posedge clock) disable iff (reset)
      (!cmd.capture && !(op_ff == OP_FIN && grid_ff == GRID_POT)) |=> $stable(energy_ff))
      else $error("energy changed outside update");
`endif

endmodule

>>> src/grid_taylor_force_interpolator.sv
// Grid Taylor force interpolator top level: CSR port, request/result channels.
// Load requests (tuser kind 0) write one grid word in the cycle they are
// accepted. Query requests are processed one at a time: the position is
// mapped to the stencil, then for each grid 19 node reads from the grid
// memory are followed by multiply steps on one shared multiplier;
// derivative mode then adds the gradient scaling on the same multiplier.
// An out-of-range query skips the node reads and goes to the output.
// The result sits in an output register so the next request can enter
// while it waits to be taken.
module grid_taylor_force_interpolator import gtfi_pkg::*; #(
   parameter int GRID_X = GRID_X_DEF,
   parameter int GRID_Y = GRID_Y_DEF,
   parameter int GRID_Z = GRID_Z_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // grid_address, grid_value, pos_x, pos_y, pos_z, clear_energy
   input  logic [143:0] req_tdata,
   // kind, table_select
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z, potential, energy_total
   output logic [191:0] rsp_tdata,
   // out_of_range
   output logic [0:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          ready;
   logic          accept;
   logic          csr_we;
   logic [2:0]    reg_idx;
   logic [31:0]   fx, fy, fz, pot;
   logic [63:0]   energy;
   logic          oor;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.inv    <= {3{32'd65536}};
         cfg_ff.cap    <= 31'h7FFFFFFF;
         cfg_ff.mode   <= '0;
      end else if (csr_we) begin
         unique case (reg_idx)
            REG_ORIGIN_X: cfg_ff.origin[0] <= csr_pwdata;
            REG_ORIGIN_Y: cfg_ff.origin[1] <= csr_pwdata;
            REG_ORIGIN_Z: cfg_ff.origin[2] <= csr_pwdata;
            REG_INV_X:    cfg_ff.inv[0]    <= csr_pwdata;
            REG_INV_Y:    cfg_ff.inv[1]    <= csr_pwdata;
            REG_INV_Z:    cfg_ff.inv[2]    <= csr_pwdata;
            REG_CAP:      cfg_ff.cap       <= csr_pwdata[30:0];
            default:      cfg_ff.mode      <= csr_pwdata[3:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ORIGIN_X: csr_prdata = cfg_ff.origin[0];
         REG_ORIGIN_Y: csr_prdata = cfg_ff.origin[1];
         REG_ORIGIN_Z: csr_prdata = cfg_ff.origin[2];
         REG_INV_X:    csr_prdata = cfg_ff.inv[0];
         REG_INV_Y:    csr_prdata = cfg_ff.inv[1];
         REG_INV_Z:    csr_prdata = cfg_ff.inv[2];
         REG_CAP:      csr_prdata = {1'b0, cfg_ff.cap};
         default:      csr_prdata = {28'd0, cfg_ff.mode};
      endcase
   end

   assign req_tready = ready;
   assign accept     = req_tvalid && ready;

   gtfi_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept_query (accept && req_tuser[0]),
      .grid_mode    (cfg_ff.mode[0]),
      .status       (status),
      .ready        (ready),
      .cmd          (cmd)
   );

   gtfi_datapath #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg_ff),
      .load_we      (accept && !req_tuser[0]),
      .table_select (req_tuser[2:1]),
      .grid_address (req_tdata[14:0]),
      .grid_value   (req_tdata[46:15]),
      .pos_x        (req_tdata[78:47]),
      .pos_y        (req_tdata[110:79]),
      .pos_z        (req_tdata[142:111]),
      .clear_energy (req_tdata[143]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .force_x      (fx),
      .force_y      (fy),
      .force_z      (fz),
      .potential    (pot),
      .energy_total (energy),
      .out_of_range (oor)
   );

   assign rsp_tdata = {energy, pot, fz, fy, fx};
   assign rsp_tuser = oor;

endmodule
